// ----- rtl/yrpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yrpp_pkg
// Types and constants shared by the YUV to RGB pixel packer modules.
// ----------------------------------------------------------------------------
package yrpp_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_CHROMA_WEIGHT   = 3'd0;
  localparam logic [2:0] REG_PIXEL_FORMAT    = 3'd1;
  localparam logic [2:0] REG_LUMA_OFFSET     = 3'd2;
  localparam logic [2:0] REG_LUMA_GAIN       = 3'd3;
  localparam logic [2:0] REG_V_TO_RED_GAIN   = 3'd4;
  localparam logic [2:0] REG_V_TO_GREEN_GAIN = 3'd5;
  localparam logic [2:0] REG_U_TO_GREEN_GAIN = 3'd6;
  localparam logic [2:0] REG_U_TO_BLUE_GAIN  = 3'd7;

  // Arithmetic constants
  localparam logic [31:0] CHROMA_OFFSET      = 32'd16384;   // 128 << 7
  localparam logic [31:0] CHROMA_PAIR_OFFSET = 32'd32768;   // 128 << 8
  localparam logic [12:0] BLEND_THRESHOLD    = 13'd2048;
  localparam logic [31:0] LUMA_ROUND         = 32'd2097152; // 1 << 21
  localparam int          OUT_SHIFT          = 22;
  localparam int          CLAMP_BIT          = 30;          // clamp at 1 << 30
  localparam logic [7:0]  ALPHA_VALUE        = 8'd255;
  localparam logic [7:0]  BYTE_MAX           = 8'd255;
  localparam logic [2:0]  BYTES_24           = 3'd3;
  localparam logic [2:0]  BYTES_32           = 3'd4;

  // Pixel byte orders
  typedef enum logic [2:0] {
    FMT_RGB24 = 3'd0,
    FMT_BGR24 = 3'd1,
    FMT_BGRA  = 3'd2,
    FMT_RGBA  = 3'd3,
    FMT_ARGB  = 3'd4,
    FMT_ABGR  = 3'd5
  } fmt_t;

  // Configuration register file contents
  typedef struct packed {
    logic        [12:0] chroma_weight;
    logic        [2:0]  pixel_format;
    logic signed [31:0] luma_offset;
    logic signed [31:0] luma_gain;
    logic signed [31:0] v_to_red_gain;
    logic signed [31:0] v_to_green_gain;
    logic signed [31:0] u_to_green_gain;
    logic signed [31:0] u_to_blue_gain;
  } cfg_t;

  // Input item
  typedef struct packed {
    logic signed [15:0] luma;
    logic signed [15:0] u_first;
    logic signed [15:0] u_second;
    logic signed [15:0] v_first;
    logic signed [15:0] v_second;
    logic               line_end;
  } in_item_t;

  // Products handed from the multiply stage to the pack stage
  typedef struct packed {
    logic [31:0] luma_prod;
    logic [31:0] vr_prod;
    logic [31:0] vg_prod;
    logic [31:0] ug_prod;
    logic [31:0] ub_prod;
    logic        line_end;
  } prod_t;

  // Result item
  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [7:0] byte_fourth;
    logic [2:0] byte_count;
    logic       line_done;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/yrpp_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yrpp_cfg_regs
// Configuration register file, written one register per cfg handshake.
// ----------------------------------------------------------------------------
module yrpp_cfg_regs (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [31:0]     cfg_data,
  output yrpp_pkg::cfg_t       cfg
);

  yrpp_pkg::cfg_t cfg_r;
  yrpp_pkg::cfg_t cfg_nxt;

  // Always take writes
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the write into the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        yrpp_pkg::REG_CHROMA_WEIGHT:   cfg_nxt.chroma_weight   = cfg_data[12:0];
        yrpp_pkg::REG_PIXEL_FORMAT:    cfg_nxt.pixel_format    = cfg_data[2:0];
        yrpp_pkg::REG_LUMA_OFFSET:     cfg_nxt.luma_offset     = cfg_data;
        yrpp_pkg::REG_LUMA_GAIN:       cfg_nxt.luma_gain       = cfg_data;
        yrpp_pkg::REG_V_TO_RED_GAIN:   cfg_nxt.v_to_red_gain   = cfg_data;
        yrpp_pkg::REG_V_TO_GREEN_GAIN: cfg_nxt.v_to_green_gain = cfg_data;
        yrpp_pkg::REG_U_TO_GREEN_GAIN: cfg_nxt.u_to_green_gain = cfg_data;
        yrpp_pkg::REG_U_TO_BLUE_GAIN:  cfg_nxt.u_to_blue_gain  = cfg_data;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/yrpp_mult_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yrpp_mult_stage
// Forms the luma and chroma terms and the five gain products (mod 2^32).
// ----------------------------------------------------------------------------
module yrpp_mult_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire yrpp_pkg::cfg_t      cfg,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire yrpp_pkg::in_item_t  up_item,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output yrpp_pkg::prod_t          dn_prod
);

  logic            vld_r;
  yrpp_pkg::prod_t prod_r;
  yrpp_pkg::prod_t prod_nxt;
  logic            blend;
  logic [31:0]     luma4;
  logic [31:0]     luma_diff;
  logic [31:0]     u_term;
  logic [31:0]     v_term;

  // Chroma term: one row, or average of both rows
  function automatic logic [31:0] chroma_term(input logic signed [15:0] first,
                                              input logic signed [15:0] second,
                                              input logic               avg);
    logic [31:0] a;
    logic [31:0] b;
    a = {{16{first[15]}}, first};
    b = {{16{second[15]}}, second};
    if (avg) begin
      chroma_term = (a + b - yrpp_pkg::CHROMA_PAIR_OFFSET) << 1;
    end else begin
      chroma_term = (a - yrpp_pkg::CHROMA_OFFSET) << 2;
    end
  endfunction

  assign blend     = (cfg.chroma_weight >= yrpp_pkg::BLEND_THRESHOLD);
  assign luma4     = {{14{up_item.luma[15]}}, up_item.luma, 2'b00};
  assign luma_diff = luma4 - cfg.luma_offset;
  assign u_term    = chroma_term(up_item.u_first, up_item.u_second, blend);
  assign v_term    = chroma_term(up_item.v_first, up_item.v_second, blend);

  // Low 32 bits of each product
  always_comb begin
    prod_nxt.luma_prod = luma_diff * cfg.luma_gain;
    prod_nxt.vr_prod   = v_term * cfg.v_to_red_gain;
    prod_nxt.vg_prod   = v_term * cfg.v_to_green_gain;
    prod_nxt.ug_prod   = u_term * cfg.u_to_green_gain;
    prod_nxt.ub_prod   = u_term * cfg.u_to_blue_gain;
    prod_nxt.line_end  = up_item.line_end;
  end

  // Advance when empty or when the next stage takes the item
  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_prod  = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/yrpp_pack_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yrpp_pack_stage
// Sums channel terms, clamps to 8 bits and packs the chosen byte order.
// ----------------------------------------------------------------------------
module yrpp_pack_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [2:0]          pixel_format,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire yrpp_pkg::prod_t     up_prod,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output yrpp_pkg::out_item_t      out_data
);

  logic                vld_r;
  yrpp_pkg::out_item_t item_r;
  yrpp_pkg::out_item_t item_nxt;
  logic [31:0]         luma_term;
  logic [7:0]          red;
  logic [7:0]          green;
  logic [7:0]          blue;

  // Clamp a signed sum to [0, 2^30], shift down, saturate 256 to 255
  function automatic logic [7:0] to_byte(input logic [31:0] sum);
    if (sum[31]) begin
      to_byte = 8'd0;
    end else if (sum[30]) begin
      to_byte = yrpp_pkg::BYTE_MAX;
    end else begin
      to_byte = sum[yrpp_pkg::CLAMP_BIT-1:yrpp_pkg::OUT_SHIFT];
    end
  endfunction

  assign luma_term = up_prod.luma_prod + yrpp_pkg::LUMA_ROUND;
  assign red   = to_byte(luma_term + up_prod.vr_prod);
  assign green = to_byte(luma_term + up_prod.vg_prod + up_prod.ug_prod);
  assign blue  = to_byte(luma_term + up_prod.ub_prod);

  // Byte order select
  always_comb begin
    item_nxt.line_done = up_prod.line_end;
    case (yrpp_pkg::fmt_t'(pixel_format))
      yrpp_pkg::FMT_BGR24: begin
        item_nxt.byte_first  = blue;
        item_nxt.byte_second = green;
        item_nxt.byte_third  = red;
        item_nxt.byte_fourth = 8'd0;
        item_nxt.byte_count  = yrpp_pkg::BYTES_24;
      end
      yrpp_pkg::FMT_BGRA: begin
        item_nxt.byte_first  = blue;
        item_nxt.byte_second = green;
        item_nxt.byte_third  = red;
        item_nxt.byte_fourth = yrpp_pkg::ALPHA_VALUE;
        item_nxt.byte_count  = yrpp_pkg::BYTES_32;
      end
      yrpp_pkg::FMT_RGBA: begin
        item_nxt.byte_first  = red;
        item_nxt.byte_second = green;
        item_nxt.byte_third  = blue;
        item_nxt.byte_fourth = yrpp_pkg::ALPHA_VALUE;
        item_nxt.byte_count  = yrpp_pkg::BYTES_32;
      end
      yrpp_pkg::FMT_ARGB: begin
        item_nxt.byte_first  = yrpp_pkg::ALPHA_VALUE;
        item_nxt.byte_second = red;
        item_nxt.byte_third  = green;
        item_nxt.byte_fourth = blue;
        item_nxt.byte_count  = yrpp_pkg::BYTES_32;
      end
      yrpp_pkg::FMT_ABGR: begin
        item_nxt.byte_first  = yrpp_pkg::ALPHA_VALUE;
        item_nxt.byte_second = blue;
        item_nxt.byte_third  = green;
        item_nxt.byte_fourth = red;
        item_nxt.byte_count  = yrpp_pkg::BYTES_32;
      end
      default: begin
        // RGB24, and unused codes pack the same way
        item_nxt.byte_first  = red;
        item_nxt.byte_second = green;
        item_nxt.byte_third  = blue;
        item_nxt.byte_fourth = 8'd0;
        item_nxt.byte_count  = yrpp_pkg::BYTES_24;
      end
    endcase
  end

  // Hold the result while the receiver stalls
  assign up_ready  = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_data  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/yuv_to_rgb_pixel_packer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_to_rgb_pixel_packer_top
// Converts one YUV pixel per item into a packed 24- or 32-bit RGB pixel.
//
// Input channel: in_valid / in_stall / in_data carry one pixel (luma, two
// chroma rows of U and V, line_end). Result channel: out_valid / out_stall /
// out_data carry the packed bytes, byte count and line_done flag.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data write one
// register per handshake; cfg_ready is always high. Write only while idle.
// Throughput: one item per clock while out_stall is low. Three register
// stages: a pixel goes from the input register to the multiply register and
// then to the result register, which drives out_data with out_valid high.
// The five 32x32 gain products in the multiply stage set the cycle time.
// Reset (rst_n low, synchronous) empties the pipe and clears the
// configuration registers to zero. A stall on the result side holds out_data
// and backs up through the stages; in_stall rises only when every stage
// holds an item.
// ----------------------------------------------------------------------------
module yuv_to_rgb_pixel_packer_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire yrpp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output yrpp_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  yrpp_pkg::cfg_t     cfg;
  logic               in_vld_r;
  yrpp_pkg::in_item_t in_item_r;
  logic               in_ready;
  logic               mult_ready;
  logic               prod_valid;
  logic               pack_ready;
  yrpp_pkg::prod_t    prod;

  yrpp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  assign in_ready = !in_vld_r || mult_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  yrpp_mult_stage u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_vld_r),
    .up_ready (mult_ready),
    .up_item  (in_item_r),
    .dn_valid (prod_valid),
    .dn_ready (pack_ready),
    .dn_prod  (prod)
  );

  yrpp_pack_stage u_pack (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_format (cfg.pixel_format),
    .up_valid     (prod_valid),
    .up_ready     (pack_ready),
    .up_prod      (prod),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YUV to RGB pixel packer. A tracker class
// predicts every packed pixel from the accepted YUV item and the register
// settings it has seen, then checks results in order. The stimulus starts
// with edge-case pixels, then runs randomized phases that cover every byte
// order, both chroma modes, extreme gains and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 85;
  localparam int HOLD_CYCLES   = 250;
  localparam int DRAIN_CYCLES  = 8;

  // Nominal studio-range coefficients at this block's scale
  localparam logic [31:0] NOM_LUMA_OFFSET = 32'd8192;
  localparam logic [31:0] NOM_LUMA_GAIN   = 32'd9535;
  localparam logic [31:0] NOM_V_RED       = 32'd13074;
  localparam logic [31:0] NOM_V_GREEN     = -32'sd6660;
  localparam logic [31:0] NOM_U_GREEN     = -32'sd3209;
  localparam logic [31:0] NOM_U_BLUE      = 32'd16525;

  // Predicts packed pixels and checks them in arrival order
  class packed_pixel_tracker;
    yrpp_pkg::cfg_t      regs;
    yrpp_pkg::out_item_t expected_pixels[$];
    int                  mismatches;

    function new();
      regs = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] index, logic [31:0] data);
      case (index)
        yrpp_pkg::REG_CHROMA_WEIGHT:   regs.chroma_weight   = data[12:0];
        yrpp_pkg::REG_PIXEL_FORMAT:    regs.pixel_format    = data[2:0];
        yrpp_pkg::REG_LUMA_OFFSET:     regs.luma_offset     = data;
        yrpp_pkg::REG_LUMA_GAIN:       regs.luma_gain       = data;
        yrpp_pkg::REG_V_TO_RED_GAIN:   regs.v_to_red_gain   = data;
        yrpp_pkg::REG_V_TO_GREEN_GAIN: regs.v_to_green_gain = data;
        yrpp_pkg::REG_U_TO_GREEN_GAIN: regs.u_to_green_gain = data;
        yrpp_pkg::REG_U_TO_BLUE_GAIN:  regs.u_to_blue_gain  = data;
        default: ;
      endcase
    endfunction

    // Single row below the blend threshold, plain two-row average at or above it
    function logic [31:0] chroma_term(logic signed [15:0] first,
                                      logic signed [15:0] second);
      int a;
      int b;
      a = first;
      b = second;
      if (regs.chroma_weight < yrpp_pkg::BLEND_THRESHOLD)
        return 32'((a - int'(yrpp_pkg::CHROMA_OFFSET)) * 4);
      return 32'((a + b - int'(yrpp_pkg::CHROMA_PAIR_OFFSET)) * 2);
    endfunction

    // Clamp to [0, 2^30], drop 22 bits, saturate 256 to 255
    function logic [7:0] to_channel(logic [31:0] sum);
      int level;
      level = sum;
      if (level < 0) level = 0;
      if (level > (1 << yrpp_pkg::CLAMP_BIT)) level = 1 << yrpp_pkg::CLAMP_BIT;
      level = level >> yrpp_pkg::OUT_SHIFT;
      if (level > int'(yrpp_pkg::BYTE_MAX)) level = int'(yrpp_pkg::BYTE_MAX);
      return level[7:0];
    endfunction

    function void take_yuv(yrpp_pkg::in_item_t px);
      logic [31:0]         luma_term;
      logic [31:0]         u_c;
      logic [31:0]         v_c;
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
      yrpp_pkg::out_item_t want;
      luma_term = (32'(int'(px.luma) * 4) - regs.luma_offset) * regs.luma_gain
                  + yrpp_pkg::LUMA_ROUND;
      u_c = chroma_term(px.u_first, px.u_second);
      v_c = chroma_term(px.v_first, px.v_second);
      red   = to_channel(luma_term + v_c * regs.v_to_red_gain);
      green = to_channel(luma_term + v_c * regs.v_to_green_gain
                         + u_c * regs.u_to_green_gain);
      blue  = to_channel(luma_term + u_c * regs.u_to_blue_gain);
      want.line_done = px.line_end;
      want.byte_count = yrpp_pkg::BYTES_32;
      // Order the bytes; unused format codes fall back to RGB24
      case (regs.pixel_format)
        yrpp_pkg::FMT_BGR24: begin
          want = '{blue, green, red, 8'd0, yrpp_pkg::BYTES_24, px.line_end};
        end
        yrpp_pkg::FMT_BGRA: begin
          want = '{blue, green, red, yrpp_pkg::ALPHA_VALUE, yrpp_pkg::BYTES_32,
                   px.line_end};
        end
        yrpp_pkg::FMT_RGBA: begin
          want = '{red, green, blue, yrpp_pkg::ALPHA_VALUE, yrpp_pkg::BYTES_32,
                   px.line_end};
        end
        yrpp_pkg::FMT_ARGB: begin
          want = '{yrpp_pkg::ALPHA_VALUE, red, green, blue, yrpp_pkg::BYTES_32,
                   px.line_end};
        end
        yrpp_pkg::FMT_ABGR: begin
          want = '{yrpp_pkg::ALPHA_VALUE, blue, green, red, yrpp_pkg::BYTES_32,
                   px.line_end};
        end
        default: begin
          want = '{red, green, blue, 8'd0, yrpp_pkg::BYTES_24, px.line_end};
        end
      endcase
      expected_pixels.push_back(want);
    endfunction

    function void check_rgb(yrpp_pkg::out_item_t got);
      yrpp_pkg::out_item_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel with nothing expected: %h %h %h %h cnt %0d line %0b",
                   got.byte_first, got.byte_second, got.byte_third, got.byte_fourth,
                   got.byte_count, got.line_done);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.byte_first !== want.byte_first || got.byte_second !== want.byte_second ||
          got.byte_third !== want.byte_third || got.byte_fourth !== want.byte_fourth ||
          got.byte_count !== want.byte_count || got.line_done !== want.line_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"pixel mismatch: expected %h %h %h %h cnt %0d line %0b, ",
                    "got %h %h %h %h cnt %0d line %0b"},
                   want.byte_first, want.byte_second, want.byte_third, want.byte_fourth,
                   want.byte_count, want.line_done,
                   got.byte_first, got.byte_second, got.byte_third, got.byte_fourth,
                   got.byte_count, got.line_done);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  yrpp_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  yrpp_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [31:0]         cfg_data;

  packed_pixel_tracker tracker;
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int cycle_count = 0;

  yuv_to_rgb_pixel_packer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL yuv_to_rgb_pixel_packer_top");
      $finish;
    end
  end

  // Observe every handshake at the edge where it completes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) tracker.take_yuv(in_data);
      if (out_valid && !out_stall) tracker.check_rgb(out_data);
    end
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 7);
      end
    end
  end

  function automatic yrpp_pkg::in_item_t make_pixel(int luma, int uf, int us, int vf,
                                                    int vs, bit le);
    yrpp_pkg::in_item_t px;
    px.luma = 16'(luma);
    px.u_first = 16'(uf);
    px.u_second = 16'(us);
    px.v_first = 16'(vf);
    px.v_second = 16'(vs);
    px.line_end = le;
    return px;
  endfunction

  // Mostly video-like pixels near neutral chroma, some fully random
  function automatic yrpp_pkg::in_item_t random_pixel();
    if ($urandom_range(3) == 0)
      return make_pixel($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(1));
    return make_pixel($urandom_range(32767),
                      16384 + $urandom_range(16000) - 8000,
                      16384 + $urandom_range(16000) - 8000,
                      16384 + $urandom_range(16000) - 8000,
                      16384 + $urandom_range(16000) - 8000,
                      $urandom_range(31) == 0);
  endfunction

  // Offer one item, idling at random first, and hold it until taken
  task automatic send_pixel(yrpp_pkg::in_item_t px);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] weight, logic [31:0] fmt, logic [31:0] offset,
                              logic [31:0] gain, logic [31:0] vr, logic [31:0] vg,
                              logic [31:0] ug, logic [31:0] ub);
    write_reg(yrpp_pkg::REG_CHROMA_WEIGHT, weight);
    write_reg(yrpp_pkg::REG_PIXEL_FORMAT, fmt);
    write_reg(yrpp_pkg::REG_LUMA_OFFSET, offset);
    write_reg(yrpp_pkg::REG_LUMA_GAIN, gain);
    write_reg(yrpp_pkg::REG_V_TO_RED_GAIN, vr);
    write_reg(yrpp_pkg::REG_V_TO_GREEN_GAIN, vg);
    write_reg(yrpp_pkg::REG_U_TO_GREEN_GAIN, ug);
    write_reg(yrpp_pkg::REG_U_TO_BLUE_GAIN, ub);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering and let every expected pixel come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    yrpp_pkg::in_item_t edge_pixels[$];
    logic [31:0]        weights[8];
    tracker = new();
    weights = '{32'd0, 32'd2048, 32'd2047, 32'd4096, 32'd1, 32'd8191, 32'd2049, 32'd3000};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= yrpp_pkg::REG_CHROMA_WEIGHT;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: all gains zero
    send_pixel(make_pixel(32767, 32767, -32768, 16384, 0, 1'b1));
    send_pixel(make_pixel(-32768, -32768, 32767, 0, 16384, 1'b0));
    send_pixel(make_pixel(0, 16384, 16384, 16384, 16384, 1'b0));
    drain();

    // Edge pixels under nominal gains: range limits, neutral and black level,
    // saturation at both ends and alternating bit patterns
    program_regs(32'd0, yrpp_pkg::FMT_RGBA, NOM_LUMA_OFFSET, NOM_LUMA_GAIN,
                 NOM_V_RED, NOM_V_GREEN, NOM_U_GREEN, NOM_U_BLUE);
    edge_pixels.push_back(make_pixel(0, 16384, 16384, 16384, 16384, 1'b0));
    edge_pixels.push_back(make_pixel(32767, 16384, 16384, 16384, 16384, 1'b0));
    edge_pixels.push_back(make_pixel(-32768, 16384, 16384, 16384, 16384, 1'b0));
    edge_pixels.push_back(make_pixel(-1, 16384, 16384, 16384, 16384, 1'b1));
    edge_pixels.push_back(make_pixel(2048, 16384, 16384, 16384, 16384, 1'b0));
    edge_pixels.push_back(make_pixel(32767, 32767, 32767, 32767, 32767, 1'b1));
    edge_pixels.push_back(make_pixel(32767, -32768, -32768, -32768, -32768, 1'b0));
    edge_pixels.push_back(make_pixel(0, 32767, -32768, -32768, 32767, 1'b0));
    edge_pixels.push_back(make_pixel(16384, 0, 0, 0, 0, 1'b0));
    edge_pixels.push_back(make_pixel(16384, -32768, 32767, 32767, -32768, 1'b1));
    edge_pixels.push_back(make_pixel(16000, 20000, 12000, 8000, 24000, 1'b0));
    edge_pixels.push_back(make_pixel(-32768, -32768, -32768, -32768, -32768, 1'b1));
    edge_pixels.push_back(make_pixel(32767, 0, 32767, 0, 32767, 1'b0));
    edge_pixels.push_back(make_pixel(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 1'b0));
    edge_pixels.push_back(make_pixel(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 1'b1));
    foreach (edge_pixels[i]) send_pixel(edge_pixels[i]);
    drain();

    // Random phases: every format code with nominal gains, then extreme
    // and fully random register values
    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 8)
        program_regs(weights[phase], phase, NOM_LUMA_OFFSET + $urandom_range(2000) - 1000,
                     NOM_LUMA_GAIN, NOM_V_RED, NOM_V_GREEN, NOM_U_GREEN, NOM_U_BLUE);
      else if (phase == 8)
        program_regs(32'd4096, yrpp_pkg::FMT_ABGR, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      else if (phase == 9)
        program_regs(32'd0, yrpp_pkg::FMT_ARGB, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      else
        program_regs($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
      calm = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == 20) hold_request = 1'b1;
        send_pixel(random_pixel());
      end
      drain();
    end
    calm = 1'b0;

    if (tracker.mismatches == 0 && tracker.expected_pixels.size() == 0)
      $display("PASS yuv_to_rgb_pixel_packer_top");
    else
      $display("FAIL yuv_to_rgb_pixel_packer_top");
    $finish;
  end

endmodule
